// ===== rtl/lsps_pkg.sv =====
// Shared types, constants and helper functions for the line sensor PID steering block.
// Used by every module in rtl/; it depends on nothing else.
package lsps_pkg;

  // Field widths
  localparam int SAMPLE_BITS   = 10;
  localparam int SUM_BITS      = 16;
  localparam int NUM_SENSORS   = 5;
  localparam int PAT_BITS      = 5;
  localparam int ERR_BITS      = 5;
  localparam int DIFF_BITS     = ERR_BITS + 1;
  localparam int GAIN_BITS     = 16;
  localparam int BASE_BITS     = 8;
  localparam int CORR_BITS     = 11;
  localparam int PWM_BITS      = 8;
  localparam int DIR_BITS      = 2;
  localparam int CLS_BITS      = 2;
  localparam int REQ_BITS      = 2;
  localparam int FRAC_BITS     = 4;

  // Product and sum widths of the PID datapath
  localparam int PP_BITS  = GAIN_BITS + ERR_BITS;
  localparam int PI_BITS  = GAIN_BITS + SUM_BITS;
  localparam int PD_BITS  = GAIN_BITS + DIFF_BITS;
  localparam int TOT_BITS = PI_BITS + 2;
  // base_speed +/- correction, signed
  localparam int DRV_BITS = CORR_BITS + 1;

  localparam int CORR_MAX = 1023;
  localparam int PWM_MAX  = 255;

  // Configuration port
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  // Stream packing
  localparam int IN_FIELD_BITS   = NUM_SENSORS * SAMPLE_BITS;
  localparam int IN_TDATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_BITS   = REQ_BITS + 1;
  localparam int OUT_FIELD_BITS  = PAT_BITS + ERR_BITS + CORR_BITS + 2 * (PWM_BITS + DIR_BITS);
  localparam int OUT_TDATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_BITS  = CLS_BITS;

  // Register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_BASE_SPEED = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_P     = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_I     = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_D     = 2'd3;

  // Register reset values (gain_p = 25.0 in Q.4)
  localparam logic [BASE_BITS-1:0]        BASE_SPEED_RST = 8'd80;
  localparam logic signed [GAIN_BITS-1:0] GAIN_P_RST     = 16'sd400;
  localparam logic signed [GAIN_BITS-1:0] GAIN_I_RST     = 16'sd0;
  localparam logic signed [GAIN_BITS-1:0] GAIN_D_RST     = 16'sd0;

  // Request kinds
  localparam logic [REQ_BITS-1:0] REQ_RUN   = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_WHITE = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_BLACK = 2'd2;

  // Line classes
  localparam logic [CLS_BITS-1:0] CLS_TRACK    = 2'd0;
  localparam logic [CLS_BITS-1:0] CLS_ALL_ON   = 2'd1;
  localparam logic [CLS_BITS-1:0] CLS_LEFT_OFF = 2'd2;
  localparam logic [CLS_BITS-1:0] CLS_CAL      = 2'd3;

  // Flagged patterns
  localparam logic [PAT_BITS-1:0] PAT_ALL_ON   = 5'b11111;
  localparam logic [PAT_BITS-1:0] PAT_LEFT_OFF = 5'b01111;

  // Motor directions
  localparam logic [DIR_BITS-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_BITS-1:0] DIR_FWD  = 2'd1;
  localparam logic [DIR_BITS-1:0] DIR_REV  = 2'd2;

  // Per-lane calibration controls
  typedef struct packed {
    logic upd_white;
    logic upd_black;
    logic wstart;
    logic wend;
  } lane_ctl_t;

  // PID stage result handed to the drive stage
  typedef struct packed {
    logic [CLS_BITS-1:0]         line_class;
    logic [PAT_BITS-1:0]         pattern;
    logic signed [ERR_BITS-1:0]  position_error;
    logic signed [CORR_BITS-1:0] correction;
  } pid_res_t;

  // One motor command
  typedef struct packed {
    logic [PWM_BITS-1:0] pwm;
    logic [DIR_BITS-1:0] dir;
  } motor_t;

  // Full result word
  typedef struct packed {
    logic [CLS_BITS-1:0]         line_class;
    logic [PAT_BITS-1:0]         pattern;
    logic signed [ERR_BITS-1:0]  position_error;
    logic signed [CORR_BITS-1:0] correction;
    motor_t                      left;
    motor_t                      right;
  } out_word_t;

  // Pattern to line offset; positive means the line is to the left
  function automatic logic signed [ERR_BITS-1:0] err_lookup(input logic [PAT_BITS-1:0] pat);
    logic signed [ERR_BITS-1:0] e;
    case (pat)
      5'b00001: e = -5'sd8;
      5'b00010: e = -5'sd3;
      5'b00011: e = -5'sd6;
      5'b00110: e = -5'sd1;
      5'b00111: e = -5'sd4;
      5'b01000: e = 5'sd3;
      5'b01100: e = 5'sd1;
      5'b10000: e = 5'sd8;
      5'b11000: e = 5'sd6;
      5'b11100: e = 5'sd4;
      default:  e = 5'sd0;
    endcase
    return e;
  endfunction

  // Signed drive level to direction and clamped duty
  function automatic motor_t drive_calc(input logic signed [DRV_BITS-1:0] v);
    motor_t m;
    logic [DRV_BITS-1:0] mag;
    mag = v[DRV_BITS-1] ? DRV_BITS'(-v) : DRV_BITS'(v);
    if (v == '0) begin
      m.dir = DIR_STOP;
    end else if (v[DRV_BITS-1]) begin
      m.dir = DIR_REV;
    end else begin
      m.dir = DIR_FWD;
    end
    m.pwm = (mag > DRV_BITS'(PWM_MAX)) ? PWM_BITS'(PWM_MAX) : mag[PWM_BITS-1:0];
    return m;
  endfunction

endpackage

// ===== rtl/line_sensor_pid_steering.sv =====
// Top level of the line sensor PID steering block: stream ports, config registers,
// five sensor lanes, PID pipeline and drive stage. Depends on lsps_pkg and all rtl modules.
//
// Usage:
//   Input words arrive on in_t* (five sensor readings in tdata, request kind and
//   window start in tuser, window end on tlast). Each word yields exactly one result
//   word on out_t* (pattern, error, correction and motor commands in tdata, line
//   class in tuser). Calibration words update the per-sensor thresholds and return
//   a result with line class 3 and all other fields zero.
//   Throughput is one word per cycle while out_tready is high: the five lanes compare
//   and update in parallel and the merge stage settles the integral in the same cycle, so
//   the next word sees the new state. Each accepted word passes the merge, gain product,
//   correction and drive registers in that order before it shows on out_tvalid.
//   When the receiver holds out_tready low, words pile up in the four pipeline
//   registers; in_tready stays high while any of them is empty.
//   Synchronous reset (rst_n low) empties the pipeline, sets thresholds to zero,
//   dark minima to full scale, clears integral and last error, and loads the
//   register defaults (base speed 80, gain_p 25.0, gain_i and gain_d zero).
//   The user writes registers through cfg_we / cfg_addr / cfg_wdata only while idle (unchecked).
module line_sensor_pid_steering (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input words
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // sample_a, sample_b, sample_c, sample_d, sample_e, zero pad
  input  logic [lsps_pkg::IN_TDATA_BITS-1:0]    in_tdata,
  // req_type, window_start
  input  logic [lsps_pkg::IN_TUSER_BITS-1:0]    in_tuser,
  // window_end
  input  logic                                  in_tlast,
  // Result words
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // pattern, position_error, correction, left_pwm, left_dir, right_pwm, right_dir, zero pad
  output logic [lsps_pkg::OUT_TDATA_BITS-1:0]   out_tdata,
  // line_class
  output logic [lsps_pkg::OUT_TUSER_BITS-1:0]   out_tuser,
  // Configuration
  input  logic                                  cfg_we,
  input  logic [lsps_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  logic [lsps_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  logic [lsps_pkg::BASE_BITS-1:0]        base_speed_r;
  logic signed [lsps_pkg::GAIN_BITS-1:0] gain_p_r, gain_i_r, gain_d_r;

  logic [lsps_pkg::REQ_BITS-1:0]         req;
  logic                                  accept;
  lsps_pkg::lane_ctl_t                   lane_ctl;
  logic [lsps_pkg::PAT_BITS-1:0]         hits;
  logic                                  pid_valid, pid_ready;
  lsps_pkg::pid_res_t                    pid_res;
  lsps_pkg::out_word_t                   out_w;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_speed_r <= lsps_pkg::BASE_SPEED_RST;
      gain_p_r     <= lsps_pkg::GAIN_P_RST;
      gain_i_r     <= lsps_pkg::GAIN_I_RST;
      gain_d_r     <= lsps_pkg::GAIN_D_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        lsps_pkg::REG_BASE_SPEED: base_speed_r <= cfg_wdata[lsps_pkg::BASE_BITS-1:0];
        lsps_pkg::REG_GAIN_P:     gain_p_r     <= $signed(cfg_wdata);
        lsps_pkg::REG_GAIN_I:     gain_i_r     <= $signed(cfg_wdata);
        lsps_pkg::REG_GAIN_D:     gain_d_r     <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Calibration controls, applied only on an accepted word
  assign req               = in_tuser[lsps_pkg::REQ_BITS-1:0];
  assign accept            = in_tvalid && in_tready;
  assign lane_ctl.upd_white = accept && (req == lsps_pkg::REQ_WHITE);
  assign lane_ctl.upd_black = accept && (req == lsps_pkg::REQ_BLACK);
  assign lane_ctl.wstart    = in_tuser[lsps_pkg::REQ_BITS];
  assign lane_ctl.wend      = in_tlast;

  // Sensor lanes; lane 0 (sensor a) drives pattern bit 4
  for (genvar k = 0; k < lsps_pkg::NUM_SENSORS; k++) begin : g_lane
    lsps_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (lane_ctl),
      .sample (in_tdata[k*lsps_pkg::SAMPLE_BITS +: lsps_pkg::SAMPLE_BITS]),
      .hit    (hits[lsps_pkg::NUM_SENSORS-1-k])
    );
  end

  lsps_pid u_pid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .req       (req),
    .hits      (hits),
    .gain_p    (gain_p_r),
    .gain_i    (gain_i_r),
    .gain_d    (gain_d_r),
    .out_valid (pid_valid),
    .out_ready (pid_ready),
    .res       (pid_res)
  );

  lsps_drive u_drive (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pid_valid),
    .in_ready   (pid_ready),
    .res        (pid_res),
    .base_speed (base_speed_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .word       (out_w)
  );

  // Pack result word
  assign out_tuser = out_w.line_class;
  assign out_tdata = lsps_pkg::OUT_TDATA_BITS'({out_w.right.dir, out_w.right.pwm,
                                               out_w.left.dir, out_w.left.pwm,
                                               out_w.correction, out_w.position_error,
                                               out_w.pattern});

  // Calibration results carry nothing but their class
  a_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_w.line_class == lsps_pkg::CLS_CAL) |->
      (out_w.pattern == '0 && out_w.correction == '0 && out_w.left == '0
       && out_w.right == '0))
    else $error("calibration result carries nonzero fields");

  // Flagged patterns never move the controller output
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_w.line_class == lsps_pkg::CLS_ALL_ON
                    || out_w.line_class == lsps_pkg::CLS_LEFT_OFF)) |->
      (out_w.position_error == '0 && out_w.correction == '0))
    else $error("flagged pattern with nonzero error or correction");

  // With no result pending the pipeline must take input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // Stop direction goes with zero duty on both motors
  a_dir_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (((out_w.left.dir == lsps_pkg::DIR_STOP) == (out_w.left.pwm == '0))
                 && ((out_w.right.dir == lsps_pkg::DIR_STOP) == (out_w.right.pwm == '0))))
    else $error("motor direction and duty disagree");

endmodule

// ===== rtl/lsps_lane.sv =====
// One sensor lane: threshold compare plus white maximum / black minimum tracking.
// Depends on lsps_pkg.
module lsps_lane (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lsps_pkg::lane_ctl_t             ctl,
  input  logic [lsps_pkg::SAMPLE_BITS-1:0] sample,
  output logic                            hit
);

  logic [lsps_pkg::SAMPLE_BITS-1:0] thresh_r, thresh_nxt;
  logic [lsps_pkg::SAMPLE_BITS-1:0] min_r, min_nxt;
  logic [lsps_pkg::SAMPLE_BITS-1:0] min_upd;
  logic [lsps_pkg::SAMPLE_BITS:0]   avg_sum;
  logic                             white_take, black_take;

  // Decision for run words uses the threshold held before this word
  assign hit = (sample >= thresh_r);

  assign white_take = ctl.wstart || (sample > thresh_r);
  assign black_take = ctl.wstart || (sample < min_r);
  assign min_upd    = black_take ? sample : min_r;
  // Window end averages the white maximum with the updated black minimum
  assign avg_sum    = {1'b0, thresh_r} + {1'b0, min_upd};

  always_comb begin
    thresh_nxt = thresh_r;
    min_nxt    = min_r;
    if (ctl.upd_white && white_take) begin
      thresh_nxt = sample;
    end
    if (ctl.upd_black) begin
      min_nxt = min_upd;
      if (ctl.wend) begin
        thresh_nxt = avg_sum[lsps_pkg::SAMPLE_BITS:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= '0;
      min_r    <= '1;
    end else begin
      thresh_r <= thresh_nxt;
      min_r    <= min_nxt;
    end
  end

endmodule

// ===== rtl/lsps_pid.sv =====
// Lane merge and PID pipeline: pattern classify, integral update, gain products,
// truncation and saturation. Depends on lsps_pkg.
module lsps_pid (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [lsps_pkg::REQ_BITS-1:0]          req,
  input  logic [lsps_pkg::PAT_BITS-1:0]          hits,
  input  logic signed [lsps_pkg::GAIN_BITS-1:0]  gain_p,
  input  logic signed [lsps_pkg::GAIN_BITS-1:0]  gain_i,
  input  logic signed [lsps_pkg::GAIN_BITS-1:0]  gain_d,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output lsps_pkg::pid_res_t                     res
);

  localparam logic signed [lsps_pkg::SUM_BITS:0] SUM_HI =
    {2'b00, {(lsps_pkg::SUM_BITS-1){1'b1}}};
  localparam logic signed [lsps_pkg::SUM_BITS:0] SUM_LO =
    {2'b11, {(lsps_pkg::SUM_BITS-1){1'b0}}};

  // PID state
  logic signed [lsps_pkg::SUM_BITS-1:0] esum_r, esum_nxt;
  logic signed [lsps_pkg::ERR_BITS-1:0] prev_r, prev_nxt;

  // Stage 1: classified word
  logic                                  v1_r;
  logic [lsps_pkg::CLS_BITS-1:0]         cls1_r, cls1_nxt;
  logic [lsps_pkg::PAT_BITS-1:0]         pat1_r, pat1_nxt;
  logic signed [lsps_pkg::ERR_BITS-1:0]  err1_r, err1_nxt;
  logic signed [lsps_pkg::SUM_BITS-1:0]  sum1_r, sum1_nxt;
  logic signed [lsps_pkg::DIFF_BITS-1:0] diff1_r, diff1_nxt;

  // Stage 2: products
  logic                                  v2_r;
  logic [lsps_pkg::CLS_BITS-1:0]         cls2_r;
  logic [lsps_pkg::PAT_BITS-1:0]         pat2_r;
  logic signed [lsps_pkg::ERR_BITS-1:0]  err2_r;
  logic signed [lsps_pkg::PP_BITS-1:0]   pp2_r, pp2_nxt;
  logic signed [lsps_pkg::PI_BITS-1:0]   pi2_r, pi2_nxt;
  logic signed [lsps_pkg::PD_BITS-1:0]   pd2_r, pd2_nxt;

  // Stage 3: correction
  logic                                  v3_r;
  lsps_pkg::pid_res_t                    res3_r, res3_nxt;

  logic                                  rdy1, rdy2, rdy3, accept, track;
  logic signed [lsps_pkg::ERR_BITS-1:0]  err_tab;
  logic signed [lsps_pkg::SUM_BITS:0]    sum_wide;
  logic signed [lsps_pkg::TOT_BITS-1:0]  total;
  logic [lsps_pkg::TOT_BITS-1:0]         mag, quo;
  logic [lsps_pkg::CORR_BITS-1:0]        corr_mag;

  // Stall chain: a stage loads when empty or when its word moves on
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign accept   = in_valid && rdy1;

  // Stage 1 merge: classify, look up error, integrate
  assign err_tab  = lsps_pkg::err_lookup(hits);
  assign sum_wide = (lsps_pkg::SUM_BITS+1)'(esum_r) + (lsps_pkg::SUM_BITS+1)'(err_tab);

  always_comb begin
    cls1_nxt  = lsps_pkg::CLS_TRACK;
    pat1_nxt  = hits;
    err1_nxt  = '0;
    sum1_nxt  = '0;
    diff1_nxt = '0;
    esum_nxt  = esum_r;
    prev_nxt  = prev_r;
    track     = 1'b0;
    if (req != lsps_pkg::REQ_RUN) begin
      cls1_nxt = lsps_pkg::CLS_CAL;
      pat1_nxt = '0;
    end else if (hits == lsps_pkg::PAT_ALL_ON) begin
      cls1_nxt = lsps_pkg::CLS_ALL_ON;
    end else if (hits == lsps_pkg::PAT_LEFT_OFF) begin
      cls1_nxt = lsps_pkg::CLS_LEFT_OFF;
    end else begin
      track = 1'b1;
    end
    if (track) begin
      err1_nxt = err_tab;
      if (sum_wide > SUM_HI) begin
        sum1_nxt = SUM_HI[lsps_pkg::SUM_BITS-1:0];
      end else if (sum_wide < SUM_LO) begin
        sum1_nxt = SUM_LO[lsps_pkg::SUM_BITS-1:0];
      end else begin
        sum1_nxt = sum_wide[lsps_pkg::SUM_BITS-1:0];
      end
      diff1_nxt = lsps_pkg::DIFF_BITS'(err_tab) - lsps_pkg::DIFF_BITS'(prev_r);
      esum_nxt  = sum1_nxt;
      prev_nxt  = err_tab;
    end
  end

  // Stage 2: three independent products
  assign pp2_nxt = gain_p * err1_r;
  assign pi2_nxt = gain_i * sum1_r;
  assign pd2_nxt = gain_d * diff1_r;

  // Stage 3: sum, drop fraction toward zero, saturate
  assign total = lsps_pkg::TOT_BITS'(pp2_r) + lsps_pkg::TOT_BITS'(pi2_r)
               + lsps_pkg::TOT_BITS'(pd2_r);
  assign mag   = total[lsps_pkg::TOT_BITS-1] ? lsps_pkg::TOT_BITS'(-total)
                                             : lsps_pkg::TOT_BITS'(total);
  assign quo   = mag >> lsps_pkg::FRAC_BITS;
  assign corr_mag = (quo > lsps_pkg::TOT_BITS'(lsps_pkg::CORR_MAX))
                  ? lsps_pkg::CORR_BITS'(lsps_pkg::CORR_MAX)
                  : quo[lsps_pkg::CORR_BITS-1:0];

  always_comb begin
    res3_nxt.line_class     = cls2_r;
    res3_nxt.pattern        = pat2_r;
    res3_nxt.position_error = err2_r;
    res3_nxt.correction     = '0;
    if (cls2_r == lsps_pkg::CLS_TRACK) begin
      res3_nxt.correction = total[lsps_pkg::TOT_BITS-1] ? -$signed(corr_mag)
                                                        : $signed(corr_mag);
    end
  end

  // Control and PID state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      esum_r <= '0;
      prev_r <= '0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (accept) begin
        esum_r <= esum_nxt;
        prev_r <= prev_nxt;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (rdy1) begin
      cls1_r  <= cls1_nxt;
      pat1_r  <= pat1_nxt;
      err1_r  <= err1_nxt;
      sum1_r  <= sum1_nxt;
      diff1_r <= diff1_nxt;
    end
    if (rdy2) begin
      cls2_r <= cls1_r;
      pat2_r <= pat1_r;
      err2_r <= err1_r;
      pp2_r  <= pp2_nxt;
      pi2_r  <= pi2_nxt;
      pd2_r  <= pd2_nxt;
    end
    if (rdy3) begin
      res3_r <= res3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign res       = res3_r;

endmodule

// ===== rtl/lsps_drive.sv =====
// Motor drive stage and output register: base speed +/- correction to direction and duty.
// Depends on lsps_pkg.
module lsps_drive (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lsps_pkg::pid_res_t              res,
  input  logic [lsps_pkg::BASE_BITS-1:0]  base_speed,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lsps_pkg::out_word_t             word
);

  logic                                  ov_r;
  lsps_pkg::out_word_t                   word_r, word_nxt;
  logic signed [lsps_pkg::DRV_BITS-1:0]  base_s, left_lvl, right_lvl;

  assign in_ready = !ov_r || out_ready;

  assign base_s    = $signed({{(lsps_pkg::DRV_BITS-lsps_pkg::BASE_BITS){1'b0}}, base_speed});
  assign left_lvl  = base_s + lsps_pkg::DRV_BITS'(res.correction);
  assign right_lvl = base_s - lsps_pkg::DRV_BITS'(res.correction);

  // Calibration words carry no drive
  always_comb begin
    word_nxt.line_class     = res.line_class;
    word_nxt.pattern        = res.pattern;
    word_nxt.position_error = res.position_error;
    word_nxt.correction     = res.correction;
    word_nxt.left           = lsps_pkg::drive_calc(left_lvl);
    word_nxt.right          = lsps_pkg::drive_calc(right_lvl);
    if (res.line_class == lsps_pkg::CLS_CAL) begin
      word_nxt.left  = '0;
      word_nxt.right = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (in_ready) begin
      ov_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = ov_r;
  assign word      = word_r;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for line_sensor_pid_steering: streams sensor words through the block
// with random gaps and back-pressure, predicts every result word and checks it field by field.
// Depends on lsps_pkg and the sources under rtl/.
module testbench;
  import lsps_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_WORDS = 110;
  localparam int MAX_REPORTS = 40;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
  localparam int SUM_MAX     = (1 << (SUM_BITS - 1)) - 1;
  localparam int SUM_MIN     = -SUM_MAX - 1;

  // Request kind with no calibration effect
  localparam logic [REQ_BITS-1:0] REQ_IDLE = 2'd3;

  // Result word field positions, lowest first
  localparam int ERR_LSB  = PAT_BITS;
  localparam int CORR_LSB = ERR_LSB + ERR_BITS;
  localparam int LPWM_LSB = CORR_LSB + CORR_BITS;
  localparam int LDIR_LSB = LPWM_LSB + PWM_BITS;
  localparam int RPWM_LSB = LDIR_LSB + DIR_BITS;
  localparam int RDIR_LSB = RPWM_LSB + PWM_BITS;

  typedef struct packed {
    logic [REQ_BITS-1:0]                     req;
    logic                                    wstart;
    logic                                    wend;
    logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] s;   // s[0] is the leftmost sensor
  } sensor_word_t;

  typedef struct packed {
    logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] thr;
    logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] dmin;
  } sensor_cal_t;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata   = '0;
  logic [IN_TUSER_BITS-1:0]  in_tuser   = '0;
  logic                      in_tlast   = 1'b0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic [OUT_TUSER_BITS-1:0] out_tuser;
  logic                      cfg_we     = 1'b0;
  logic [CFG_ADDR_BITS-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata  = '0;

  // Register mirror, written only while the block is idle
  logic [BASE_BITS-1:0]        base_speed_q = BASE_SPEED_RST;
  logic signed [GAIN_BITS-1:0] gain_p_q     = GAIN_P_RST;
  logic signed [GAIN_BITS-1:0] gain_i_q     = GAIN_I_RST;
  logic signed [GAIN_BITS-1:0] gain_d_q     = GAIN_D_RST;

  // Calibration state as the block holds it, and as planned by the word generator
  sensor_cal_t live_cal = '{thr: '0, dmin: '1};
  sensor_cal_t plan_cal = '{thr: '0, dmin: '1};
  longint      err_sum  = 0;
  longint      last_err = 0;

  sensor_word_t pending_words[$];
  out_word_t    expected_words[$];

  logic in_fire     = 1'b0;
  int   idle_cycles = 0;
  int   fail_count  = 0;
  int   words_queued = 0;
  int   n_cal = 0, n_track = 0, n_flag = 0, n_settings = 0;
  int   gap_left = 0, burst_left = 0;
  int   rx_span = 0, rx_mode = 0;
  logic [15:0] rx_bits = 16'h0001;

  line_sensor_pid_steering u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pattern to signed line offset; anything off the table reads as centered
  function automatic int line_offset(input logic [PAT_BITS-1:0] pat);
    int off;
    case (pat)
      5'b10000: off = 8;
      5'b11000: off = 6;
      5'b11100: off = 4;
      5'b01000: off = 3;
      5'b01100: off = 1;
      5'b00110: off = -1;
      5'b00010: off = -3;
      5'b00111: off = -4;
      5'b00011: off = -6;
      5'b00001: off = -8;
      default:  off = 0;
    endcase
    return off;
  endfunction

  // White words raise maxima, black words lower minima and average on window end
  function automatic sensor_cal_t cal_next(input sensor_cal_t c, input sensor_word_t w);
    sensor_cal_t n;
    logic [SAMPLE_BITS:0] mid;
    n = c;
    for (int k = 0; k < NUM_SENSORS; k++) begin
      if (w.req == REQ_WHITE) begin
        if (w.wstart || w.s[k] > c.thr[k]) n.thr[k] = w.s[k];
      end else if (w.req == REQ_BLACK) begin
        if (w.wstart || w.s[k] < c.dmin[k]) n.dmin[k] = w.s[k];
        if (w.wend) begin
          mid = ({1'b0, c.thr[k]} + {1'b0, n.dmin[k]}) >> 1;
          n.thr[k] = mid[SAMPLE_BITS-1:0];
        end
      end
    end
    return n;
  endfunction

  // Signed drive level to direction and clamped duty
  function automatic motor_t motor_cmd(input longint level);
    motor_t m;
    longint mag;
    mag = (level < 0) ? -level : level;
    if (level > 0) m.dir = DIR_FWD;
    else if (level < 0) m.dir = DIR_REV;
    else m.dir = DIR_STOP;
    m.pwm = (mag > PWM_MAX) ? '1 : mag[PWM_BITS-1:0];
    return m;
  endfunction

  function automatic sensor_word_t sensor_word(input logic [REQ_BITS-1:0] req,
                                               input logic ws, input logic we,
                                               input int a, input int b, input int c,
                                               input int d, input int e);
    sensor_word_t w;
    w.req = req;
    w.wstart = ws;
    w.wend = we;
    w.s = {e[SAMPLE_BITS-1:0], d[SAMPLE_BITS-1:0], c[SAMPLE_BITS-1:0],
           b[SAMPLE_BITS-1:0], a[SAMPLE_BITS-1:0]};
    return w;
  endfunction

  function automatic sensor_word_t random_word(input logic [REQ_BITS-1:0] req,
                                               input int lo, input int hi);
    sensor_word_t w;
    w = '0;
    w.req = req;
    for (int k = 0; k < NUM_SENSORS; k++) w.s[k] = SAMPLE_BITS'($urandom_range(hi, lo));
    return w;
  endfunction

  // Expected result for one accepted word; updates the tracked block state
  task automatic steer_predict(input sensor_word_t w);
    out_word_t x;
    logic [PAT_BITS-1:0] pat;
    longint e, total, corr;
    x = '0;
    if (w.req != REQ_RUN) begin
      live_cal = cal_next(live_cal, w);
      x.line_class = CLS_CAL;
      n_cal++;
    end else begin
      pat = '0;
      for (int k = 0; k < NUM_SENSORS; k++) pat[PAT_BITS-1-k] = (w.s[k] >= live_cal.thr[k]);
      x.pattern = pat;
      if (pat inside {PAT_ALL_ON, PAT_LEFT_OFF}) begin
        // junction-like patterns: PID state frozen, straight ahead at base speed
        x.line_class = (pat == PAT_ALL_ON) ? CLS_ALL_ON : CLS_LEFT_OFF;
        x.left = motor_cmd(longint'(base_speed_q));
        x.right = x.left;
        n_flag++;
      end else begin
        e = line_offset(pat);
        err_sum = err_sum + e;
        if (err_sum > SUM_MAX) err_sum = SUM_MAX;
        if (err_sum < SUM_MIN) err_sum = SUM_MIN;
        total = longint'(gain_p_q) * e + longint'(gain_i_q) * err_sum
              + longint'(gain_d_q) * (e - last_err);
        last_err = e;
        // Q.4 scaling, truncated toward zero
        corr = (total < 0) ? -((-total) >>> FRAC_BITS) : (total >>> FRAC_BITS);
        if (corr > CORR_MAX) corr = CORR_MAX;
        if (corr < -CORR_MAX) corr = -CORR_MAX;
        x.line_class = CLS_TRACK;
        x.position_error = e[ERR_BITS-1:0];
        x.correction = corr[CORR_BITS-1:0];
        x.left = motor_cmd(longint'(base_speed_q) + corr);
        x.right = motor_cmd(longint'(base_speed_q) - corr);
        n_track++;
      end
    end
    expected_words.push_back(x);
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic queue_word(input sensor_word_t w);
    pending_words.push_back(w);
    plan_cal = cal_next(plan_cal, w);
    words_queued++;
  endtask

  // Run word aiming at the requested pattern under the planned thresholds; zero-threshold lanes always hit
  task automatic queue_run(input logic [PAT_BITS-1:0] pat);
    sensor_word_t w;
    w = '0;
    w.req = REQ_RUN;
    for (int k = 0; k < NUM_SENSORS; k++) begin
      if (pat[PAT_BITS-1-k] || plan_cal.thr[k] == 0)
        w.s[k] = SAMPLE_BITS'($urandom_range(SAMPLE_MAX, plan_cal.thr[k]));
      else
        w.s[k] = SAMPLE_BITS'($urandom_range(plan_cal.thr[k] - 1, 0));
    end
    queue_word(w);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [BASE_BITS-1:0] speed,
                            input logic signed [GAIN_BITS-1:0] kp,
                            input logic signed [GAIN_BITS-1:0] ki,
                            input logic signed [GAIN_BITS-1:0] kd);
    write_reg(REG_BASE_SPEED, {{(CFG_DATA_BITS-BASE_BITS){1'b0}}, speed});
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    base_speed_q = speed;
    gain_p_q = kp;
    gain_i_q = ki;
    gain_d_q = kd;
    n_settings++;
  endtask

  // Block is idle once every queued word went in and every result came back;
  // checked again after the settle cycles in case the last word was just launched
  task automatic wait_idle();
    do begin
      while (pending_words.size() != 0 || in_tvalid || expected_words.size() != 0)
        @(negedge clk);
      repeat (6) @(negedge clk);
    end while (pending_words.size() != 0 || in_tvalid || expected_words.size() != 0);
  endtask

  // Word driver: bursts of random length with random gaps, valid held until taken
  always @(negedge clk) begin : word_driver
    sensor_word_t w;
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (gap_left > 0 || pending_words.size() == 0) begin
        in_tvalid <= 1'b0;
        if (gap_left > 0) gap_left = gap_left - 1;
      end else begin
        w = pending_words.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {{(IN_TDATA_BITS-IN_FIELD_BITS){1'b0}}, w.s};
        in_tuser <= {w.wstart, w.req};
        in_tlast <= w.wend;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left = burst_left - 1;
        end
      end
    end
  end

  // Result side ready: free-running, rotating random mask, or one slot in sixteen
  always @(negedge clk) begin : result_ready
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_span = $urandom_range(16, 160);
      if (rx_mode == 2) rx_bits = 16'h0001 << $urandom_range(0, 15);
      else rx_bits = $urandom | (16'h0001 << $urandom_range(0, 15));
    end
    rx_span = rx_span - 1;
    rx_bits = {rx_bits[0], rx_bits[15:1]};
    out_tready <= (rx_mode == 0) ? 1'b1 : rx_bits[0];
  end

  // Monitor: predict on accepted input words, check accepted result words, watchdog
  always @(posedge clk) begin : result_monitor
    sensor_word_t got_in;
    out_word_t want;
    logic in_take, out_take;
    in_take = in_tvalid && in_tready;
    out_take = out_tvalid && out_tready;
    if (rst_n) begin
      in_fire <= in_take;
      if (in_take) begin
        got_in = {in_tuser[REQ_BITS-1:0], in_tuser[REQ_BITS], in_tlast,
                  in_tdata[IN_FIELD_BITS-1:0]};
        steer_predict(got_in);
      end
      if (out_take) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: result word %h with none expected", $time, out_tdata);
        end else begin
          want = expected_words.pop_front();
          check_field("line_class", int'(want.line_class), int'(out_tuser));
          check_field("pattern", int'(want.pattern), int'(out_tdata[PAT_BITS-1:0]));
          check_field("position_error", int'(want.position_error),
                      int'($signed(out_tdata[ERR_LSB +: ERR_BITS])));
          check_field("correction", int'(want.correction),
                      int'($signed(out_tdata[CORR_LSB +: CORR_BITS])));
          check_field("left_pwm", int'(want.left.pwm), int'(out_tdata[LPWM_LSB +: PWM_BITS]));
          check_field("left_dir", int'(want.left.dir), int'(out_tdata[LDIR_LSB +: DIR_BITS]));
          check_field("right_pwm", int'(want.right.pwm),
                      int'(out_tdata[RPWM_LSB +: PWM_BITS]));
          check_field("right_dir", int'(want.right.dir),
                      int'(out_tdata[RDIR_LSB +: DIR_BITS]));
        end
      end
      if (in_take || out_take) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    sensor_word_t w;
    logic [PAT_BITS-1:0] p;
    int kind, n, r, target;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: calibration corner cases first, then every table entry at reset gains
    queue_word(sensor_word(REQ_BLACK, 1'b1, 1'b1, 0, SAMPLE_MAX, 512, 1, SAMPLE_MAX - 1));
    queue_word(sensor_word(REQ_RUN, 1'b0, 1'b0, 0, 0, 0, 0, 0));
    queue_word(sensor_word(REQ_WHITE, 1'b1, 1'b0, 800, 820, 840, 860, 880));
    queue_word(sensor_word(REQ_WHITE, 1'b0, 1'b0, 900, 700, SAMPLE_MAX, 600, 0));
    // window end on a white word has no effect
    queue_word(sensor_word(REQ_WHITE, 1'b0, 1'b1, 10, 10, 10, 10, 10));
    queue_word(sensor_word(REQ_BLACK, 1'b1, 1'b0, 100, 120, 0, 140, 160));
    queue_word(sensor_word(REQ_BLACK, 1'b0, 1'b0, 50, 200, 20, 100, 300));
    queue_word(sensor_word(REQ_BLACK, 1'b0, 1'b1, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                           SAMPLE_MAX, SAMPLE_MAX));
    queue_word(sensor_word(REQ_IDLE, 1'b1, 1'b1, $urandom_range(0, SAMPLE_MAX),
                           SAMPLE_MAX, 0, $urandom_range(0, SAMPLE_MAX), 0));
    queue_run(5'b10000);
    queue_run(5'b11000);
    queue_run(5'b11100);
    queue_run(5'b01100);
    queue_run(5'b01000);
    queue_run(5'b00110);
    queue_run(5'b00010);
    queue_run(5'b00111);
    queue_run(5'b00011);
    queue_run(5'b00001);
    queue_run(5'b00000);
    queue_run(PAT_LEFT_OFF);
    queue_run(PAT_ALL_ON);
    queue_run(5'b10101);
    queue_run(5'b01100);
    wait_idle();

    // Random phases, one register setting each, extremes first
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(8'd255, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        1: set_config(8'd0, 16'sh8000, 16'sh8000, 16'sh8000);
        2: set_config(8'd0, GAIN_P_RST, GAIN_I_RST, GAIN_D_RST);
        7: set_config(BASE_BITS'($urandom), GAIN_BITS'($urandom), GAIN_BITS'($urandom),
                      GAIN_BITS'($urandom));
        default: set_config(BASE_BITS'($urandom_range(0, 255)),
                            GAIN_BITS'($urandom_range(0, 4095) - 2048),
                            GAIN_BITS'($urandom_range(0, 255) - 128),
                            GAIN_BITS'($urandom_range(0, 4095) - 2048));
      endcase
      target = words_queued + PHASE_WORDS;
      while (words_queued < target) begin
        kind = $urandom_range(0, 99);
        n = $urandom_range(2, 6);
        if (kind < 15) begin
          // white window, mostly opened properly, stray window ends
          for (int j = 0; j < n; j++) begin
            w = random_word(REQ_WHITE, 500, SAMPLE_MAX);
            w.wstart = (j == 0) && ($urandom_range(0, 9) != 0);
            w.wend = ($urandom_range(0, 4) == 0);
            queue_word(w);
          end
        end else if (kind < 30) begin
          // black window, usually closed with the averaging step
          for (int j = 0; j < n; j++) begin
            w = random_word(REQ_BLACK, 0, 400);
            w.wstart = (j == 0) && ($urandom_range(0, 9) != 0);
            w.wend = (j == n - 1) && ($urandom_range(0, 6) != 0);
            queue_word(w);
          end
        end else if (kind < 85) begin
          // tracking run: mostly table patterns, some flagged and off-table
          n = $urandom_range(4, 12);
          for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 19);
            if (r < 2) begin
              queue_run((r == 0) ? PAT_ALL_ON : PAT_LEFT_OFF);
            end else if (r < 5) begin
              queue_run(PAT_BITS'($urandom_range(0, 31)));
            end else begin
              do p = PAT_BITS'($urandom_range(0, 31)); while (line_offset(p) == 0 && p != 0);
              queue_run(p);
            end
          end
        end else begin
          // noise: any request kind, any flags, full-range samples
          for (int j = 0; j < n / 2 + 1; j++) begin
            w = random_word(REQ_BITS'($urandom_range(0, 3)), 0, SAMPLE_MAX);
            w.wstart = 1'($urandom_range(0, 1));
            w.wend = 1'($urandom_range(0, 1));
            queue_word(w);
          end
        end
      end
      wait_idle();
    end

    // Integral walk: unit integral gain, drive the sum down and then back up
    set_config(BASE_BITS'($urandom_range(0, 255)), 16'sd0, 16'sd1, 16'sd0);
    queue_word(sensor_word(REQ_WHITE, 1'b1, 1'b0, 900, 900, 900, 900, 900));
    queue_word(sensor_word(REQ_BLACK, 1'b1, 1'b1, 100, 100, 100, 100, 100));
    repeat (150) queue_run(5'b00001);
    repeat (150) queue_run(5'b10000);
    wait_idle();

    $display("Covered %0d words: %0d calibration, %0d tracking, %0d on junction patterns",
             n_cal + n_track + n_flag, n_cal, n_track, n_flag);
    $display("%0d register settings, ending with an integral walk down and back", n_settings);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
